/* src/crmfm_pkg.sv */
// Shared types, codes and constants for the CAN receive filter with message objects.
package crmfm_pkg;

    localparam int NUM_OBJECTS_DEF    = 16;
    localparam int MAX_RING_DEPTH_DEF = 16;

    localparam int ID_W    = 29;
    localparam int STD_W   = 16;
    localparam int DLC_W   = 4;
    localparam int DATA_W  = 64;
    localparam int TIME_W  = 32;
    localparam int DEPTH_W = 5;
    localparam int MAP_W   = 16;
    localparam int IDX_W   = 4;
    localparam int ACT_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 152;

    typedef enum logic [ACT_W-1:0] {
        ACT_RX     = 3'd0,
        ACT_POP    = 3'd1,
        ACT_CONFIG = 3'd2,
        ACT_CLEAR  = 3'd3,
        ACT_CHANGE = 3'd4
    } act_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BUS_OPEN  = 2'd0,
        REG_STD_MASK  = 2'd1,
        REG_EXT_MASK  = 2'd2,
        REG_LAST_MASK = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OBJ,
        ST_SLOT,
        ST_DONE
    } state_t;

    // One message object: filter plus ring bookkeeping.
    typedef struct packed {
        logic [ID_W-1:0]    filter_id;
        logic               filter_ext;
        logic [DEPTH_W-1:0] depth;
        logic [DEPTH_W-1:0] count;
        logic [DEPTH_W-1:0] wptr;
        logic [DEPTH_W-1:0] rptr;
    } obj_t;

    // One stored frame.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic              ext;
        logic [DLC_W-1:0]  dlc;
        logic [DATA_W-1:0] data;
        logic [TIME_W-1:0] stamp;
    } slot_t;

endpackage

/* src/crmfm_obj_mem.sv */
// Message object state memory with per-entry valid bits for reset.
module crmfm_obj_mem #(
    parameter int NUM_OBJECTS = crmfm_pkg::NUM_OBJECTS_DEF,
    parameter int OBJ_W       = $clog2(NUM_OBJECTS)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [OBJ_W-1:0]  rd_addr,
    output crmfm_pkg::obj_t   rd_data,
    input  logic              wr_en,
    input  logic [OBJ_W-1:0]  wr_addr,
    input  crmfm_pkg::obj_t   wr_data
);

    crmfm_pkg::obj_t         mem [NUM_OBJECTS];
    logic [NUM_OBJECTS-1:0]  vld_reg;
    crmfm_pkg::obj_t         rd_raw_reg;
    logic                    rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_raw_reg <= mem[rd_addr];
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // An entry never written reads as an inactive, empty object.
    always_comb begin
        rd_data = rd_raw_reg;
        if (!rd_vld_reg) begin
            rd_data.filter_ext = 1'b0;
            rd_data.depth      = '0;
            rd_data.count      = '0;
            rd_data.wptr       = '0;
            rd_data.rptr       = '0;
        end
    end

endmodule

/* src/crmfm_slot_mem.sv */
// Frame storage memory holding the ring slots of all message objects.
module crmfm_slot_mem #(
    parameter int NUM_SLOTS = crmfm_pkg::NUM_OBJECTS_DEF * crmfm_pkg::MAX_RING_DEPTH_DEF,
    parameter int SLOT_AW   = $clog2(NUM_SLOTS)
) (
    input  logic               aclk,
    input  logic               rd_en,
    input  logic [SLOT_AW-1:0] rd_addr,
    output crmfm_pkg::slot_t   rd_data,
    input  logic               wr_en,
    input  logic [SLOT_AW-1:0] wr_addr,
    input  crmfm_pkg::slot_t   wr_data
);

    crmfm_pkg::slot_t mem [NUM_SLOTS];
    crmfm_pkg::slot_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/can_rx_mask_filter_mailboxes.sv */
// Top level of the CAN receive filter with message objects and ring buffers.
//
// The block keeps NUM_OBJECTS message objects in a small object memory and
// their stored frames in one slot memory of NUM_OBJECTS * MAX_RING_DEPTH
// entries; both memories have a registered read. One item is worked on at
// a time. A receive (action 0) with the bus open sweeps the object memory
// one object per cycle: the object read in one cycle is matched, updated
// and written back in the next while the following object is read, and a
// matching object also writes the frame into its ring slot, dropping the
// oldest entry when the ring is full. A pop that finds a message reads the
// object, then its oldest slot; a pop of an empty or inactive object,
// configure, clear, change filter, a receive with the bus closed and unknown
// actions read only the object. Every item produces exactly one result item,
// held in an output register so that the next item is accepted while the
// result waits to be taken. Configuration writes are accepted in any cycle
// and should only be issued while idle.
module can_rx_mask_filter_mailboxes #(
    parameter int NUM_OBJECTS    = crmfm_pkg::NUM_OBJECTS_DEF,
    parameter int MAX_RING_DEPTH = crmfm_pkg::MAX_RING_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input items.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // obj_index[3:0], frame_id[32:4], frame_ext[33], frame_dlc[37:34],
    // frame_data[101:38], frame_time[133:102], obj_depth[138:134], zero pad.
    input  logic [crmfm_pkg::S_TDATA_W-1:0]     s_tdata,
    // action[2:0].
    input  logic [crmfm_pkg::ACT_W-1:0]         s_tuser,
    // Result items.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // msg_id[28:0], msg_ext[29], msg_dlc[33:30], msg_data[97:34],
    // msg_time[129:98], obj_count[134:130], accept_map[150:135], zero pad.
    output logic [crmfm_pkg::M_TDATA_W-1:0]     m_tdata,
    // msg_valid[0].
    output logic                                m_tuser,
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [crmfm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [crmfm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int OBJ_W     = $clog2(NUM_OBJECTS);
    localparam int NUM_SLOTS = NUM_OBJECTS * MAX_RING_DEPTH;
    localparam int SLOT_AW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int KCMP_W    = 7;

    localparam logic [OBJ_W-1:0]   LAST_OBJ = OBJ_W'(NUM_OBJECTS - 1);
    localparam logic [SLOT_AW-1:0] RING_STRIDE = SLOT_AW'(MAX_RING_DEPTH);

    // Configuration registers.
    logic                        bus_open_reg;
    logic [crmfm_pkg::STD_W-1:0] std_mask_reg;
    logic [crmfm_pkg::ID_W-1:0]  ext_mask_reg;
    logic [crmfm_pkg::ID_W-1:0]  last_mask_reg;

    // Sequencer state and the item being worked on.
    crmfm_pkg::state_t             state_reg, state_next;
    logic [crmfm_pkg::ACT_W-1:0]   act_reg, act_next;
    logic [crmfm_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [crmfm_pkg::ID_W-1:0]    id_reg, id_next;
    logic                          ext_reg, ext_next;
    logic [crmfm_pkg::DLC_W-1:0]   dlc_reg, dlc_next;
    logic [crmfm_pkg::DATA_W-1:0]  data_reg, data_next;
    logic [crmfm_pkg::TIME_W-1:0]  time_reg, time_next;
    logic [crmfm_pkg::DEPTH_W-1:0] depth_reg, depth_next;
    logic [OBJ_W-1:0]              pos_reg, pos_next;

    // Result being built.
    logic [crmfm_pkg::MAP_W-1:0]   map_reg, map_next;
    logic [crmfm_pkg::DEPTH_W-1:0] cnt_reg, cnt_next;
    logic                          msgv_reg, msgv_next;
    crmfm_pkg::slot_t              msg_reg, msg_next;

    // Output register.
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [crmfm_pkg::M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                              m_tuser_reg, m_tuser_next;

    // Memory ports.
    logic              obj_rd_en, obj_wr_en;
    logic [OBJ_W-1:0]  obj_rd_addr, obj_wr_addr;
    crmfm_pkg::obj_t   obj_rd, obj_wr;
    logic                 slot_rd_en, slot_wr_en;
    logic [SLOT_AW-1:0]   slot_rd_addr, slot_wr_addr;
    crmfm_pkg::slot_t     slot_rd, slot_wr;

    // Helpers.
    logic                        k_ok;
    logic [OBJ_W-1:0]            k_addr;
    logic [KCMP_W-1:0]           k_wide;
    logic [crmfm_pkg::ID_W-1:0]  cmp_mask;
    logic                        obj_match;
    crmfm_pkg::obj_t             obj_upd;
    logic [crmfm_pkg::DEPTH_W-1:0] wptr_inc, rptr_inc, sat_depth;
    logic [crmfm_pkg::DATA_W-1:0]  data_masked;
    logic                        out_free;

    crmfm_obj_mem #(
        .NUM_OBJECTS (NUM_OBJECTS),
        .OBJ_W       (OBJ_W)
    ) u_obj_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (obj_rd_en),
        .rd_addr (obj_rd_addr),
        .rd_data (obj_rd),
        .wr_en   (obj_wr_en),
        .wr_addr (obj_wr_addr),
        .wr_data (obj_wr)
    );

    crmfm_slot_mem #(
        .NUM_SLOTS (NUM_SLOTS),
        .SLOT_AW   (SLOT_AW)
    ) u_slot_mem (
        .aclk    (aclk),
        .rd_en   (slot_rd_en),
        .rd_addr (slot_rd_addr),
        .rd_data (slot_rd),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr)
    );

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bus_open_reg  <= 1'b0;
            std_mask_reg  <= '1;
            ext_mask_reg  <= '1;
            last_mask_reg <= '1;
        end else if (cfg_valid) begin
            unique case (crmfm_pkg::cfg_reg_t'(cfg_index))
                crmfm_pkg::REG_BUS_OPEN:  bus_open_reg  <= cfg_data[0];
                crmfm_pkg::REG_STD_MASK:  std_mask_reg  <= cfg_data[crmfm_pkg::STD_W-1:0];
                crmfm_pkg::REG_EXT_MASK:  ext_mask_reg  <= cfg_data[crmfm_pkg::ID_W-1:0];
                crmfm_pkg::REG_LAST_MASK: last_mask_reg <= cfg_data[crmfm_pkg::ID_W-1:0];
                default: ;
            endcase
        end
    end

    // The addressed object: its index is checked against the object count.
    assign k_wide = KCMP_W'(idx_reg);
    assign k_ok   = k_wide < KCMP_W'(NUM_OBJECTS);
    assign k_addr = k_wide[OBJ_W-1:0];

    // Acceptance compare for the object being swept. Standard frames only
    // see the low sixteen identifier bits because the mask is zero above.
    always_comb begin
        cmp_mask = ext_reg ? ext_mask_reg
                           : {{(crmfm_pkg::ID_W-crmfm_pkg::STD_W){1'b0}}, std_mask_reg};
        if (pos_reg == LAST_OBJ) begin
            cmp_mask = cmp_mask & last_mask_reg;
        end
        obj_match = (obj_rd.depth != '0) && (obj_rd.filter_ext == ext_reg) &&
                    ((id_reg & cmp_mask) == (obj_rd.filter_id & cmp_mask));
    end

    // Ring pointer steps wrap at the object's own depth.
    assign wptr_inc = (obj_rd.wptr + 5'd1 == obj_rd.depth) ? '0 : obj_rd.wptr + 5'd1;
    assign rptr_inc = (obj_rd.rptr + 5'd1 == obj_rd.depth) ? '0 : obj_rd.rptr + 5'd1;
    assign sat_depth = (KCMP_W'(depth_reg) > KCMP_W'(MAX_RING_DEPTH))
                       ? crmfm_pkg::DEPTH_W'(MAX_RING_DEPTH) : depth_reg;

    // Bytes beyond the data length code are stored as zero.
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            data_masked[8*b +: 8] = (dlc_reg > crmfm_pkg::DLC_W'(b)) ? data_reg[8*b +: 8]
                                                                      : 8'h00;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == crmfm_pkg::ST_IDLE);

    always_comb begin
        state_next = state_reg;
        act_next   = act_reg;
        idx_next   = idx_reg;
        id_next    = id_reg;
        ext_next   = ext_reg;
        dlc_next   = dlc_reg;
        data_next  = data_reg;
        time_next  = time_reg;
        depth_next = depth_reg;
        pos_next   = pos_reg;
        map_next   = map_reg;
        cnt_next   = cnt_reg;
        msgv_next  = msgv_reg;
        msg_next   = msg_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        obj_rd_en    = 1'b0;
        obj_rd_addr  = '0;
        obj_wr_en    = 1'b0;
        obj_wr_addr  = pos_reg;
        obj_wr       = obj_rd;
        slot_rd_en   = 1'b0;
        slot_rd_addr = SLOT_AW'(k_addr) * RING_STRIDE + SLOT_AW'(obj_rd.rptr);
        slot_wr_en   = 1'b0;
        slot_wr_addr = SLOT_AW'(pos_reg) * RING_STRIDE + SLOT_AW'(obj_rd.wptr);
        slot_wr      = '{id: id_reg, ext: ext_reg, dlc: dlc_reg, data: data_masked,
                         stamp: time_reg};

        obj_upd = obj_rd;
        obj_upd.wptr = wptr_inc;
        if (obj_rd.count >= obj_rd.depth) begin
            obj_upd.rptr = wptr_inc;
        end else begin
            obj_upd.count = obj_rd.count + 5'd1;
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            crmfm_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    act_next   = s_tuser;
                    idx_next   = s_tdata[3:0];
                    id_next    = s_tdata[32:4];
                    ext_next   = s_tdata[33];
                    dlc_next   = s_tdata[37:34];
                    data_next  = s_tdata[101:38];
                    time_next  = s_tdata[133:102];
                    depth_next = s_tdata[138:134];
                    pos_next   = '0;
                    map_next   = '0;
                    cnt_next   = '0;
                    msgv_next  = 1'b0;
                    msg_next   = '0;
                    obj_rd_en  = 1'b1;
                    if (s_tuser == crmfm_pkg::ACT_RX && bus_open_reg) begin
                        obj_rd_addr = '0;
                        state_next  = crmfm_pkg::ST_SCAN;
                    end else begin
                        obj_rd_addr = OBJ_W'(KCMP_W'(s_tdata[3:0]));
                        state_next  = crmfm_pkg::ST_OBJ;
                    end
                end
            end

            // Object pos_reg is on the read port; object pos_reg + 1 is read.
            crmfm_pkg::ST_SCAN: begin
                if (obj_match) begin
                    obj_wr_en  = 1'b1;
                    obj_wr     = obj_upd;
                    slot_wr_en = 1'b1;
                    map_next   = map_reg | (crmfm_pkg::MAP_W'(1) << pos_reg);
                end
                if (k_ok && pos_reg == k_addr) begin
                    cnt_next = obj_match ? obj_upd.count : obj_rd.count;
                end
                if (pos_reg == LAST_OBJ) begin
                    state_next = crmfm_pkg::ST_DONE;
                end else begin
                    obj_rd_en   = 1'b1;
                    obj_rd_addr = pos_reg + OBJ_W'(1);
                    pos_next    = pos_reg + OBJ_W'(1);
                end
            end

            crmfm_pkg::ST_OBJ: begin
                state_next  = crmfm_pkg::ST_DONE;
                obj_wr_addr = k_addr;
                if (k_ok) begin
                    cnt_next = obj_rd.count;
                    priority case (act_reg)
                        crmfm_pkg::ACT_POP: begin
                            if (obj_rd.count != '0) begin
                                slot_rd_en     = 1'b1;
                                obj_wr_en      = 1'b1;
                                obj_wr.rptr    = rptr_inc;
                                obj_wr.count   = obj_rd.count - 5'd1;
                                cnt_next       = obj_rd.count - 5'd1;
                                msgv_next      = 1'b1;
                                state_next     = crmfm_pkg::ST_SLOT;
                            end
                        end
                        crmfm_pkg::ACT_CONFIG: begin
                            obj_wr_en    = 1'b1;
                            obj_wr.depth = sat_depth;
                            if (sat_depth != '0) begin
                                obj_wr.filter_id  = id_reg;
                                obj_wr.filter_ext = ext_reg;
                            end
                            obj_wr.count = '0;
                            obj_wr.wptr  = '0;
                            obj_wr.rptr  = '0;
                            cnt_next     = '0;
                        end
                        crmfm_pkg::ACT_CLEAR: begin
                            obj_wr_en    = 1'b1;
                            obj_wr.count = '0;
                            obj_wr.wptr  = '0;
                            obj_wr.rptr  = '0;
                            cnt_next     = '0;
                        end
                        crmfm_pkg::ACT_CHANGE: begin
                            obj_wr_en         = 1'b1;
                            obj_wr.filter_id  = id_reg;
                            obj_wr.filter_ext = ext_reg;
                        end
                        default: ;
                    endcase
                end
            end

            crmfm_pkg::ST_SLOT: begin
                msg_next   = slot_rd;
                state_next = crmfm_pkg::ST_DONE;
            end

            crmfm_pkg::ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = msgv_reg;
                    m_tdata_next  = {1'b0, map_reg, cnt_reg, msg_reg.stamp, msg_reg.data,
                                     msg_reg.dlc, msg_reg.ext, msg_reg.id};
                    state_next    = crmfm_pkg::ST_IDLE;
                end
            end

            default: state_next = crmfm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= crmfm_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg     <= act_next;
        idx_reg     <= idx_next;
        id_reg      <= id_next;
        ext_reg     <= ext_next;
        dlc_reg     <= dlc_next;
        data_reg    <= data_next;
        time_reg    <= time_next;
        depth_reg   <= depth_next;
        pos_reg     <= pos_next;
        map_reg     <= map_next;
        cnt_reg     <= cnt_next;
        msgv_reg    <= msgv_next;
        msg_reg     <= msg_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // A pop result never reports stored objects.
    a_pop_no_map: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[150:135] == '0))
        else $error("pop result carries an accept map");

    // Without a popped message the message fields are all zero.
    a_empty_msg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[129:0] == '0))
        else $error("message fields set without a popped message");

    // Frames are written to the slot memory only during the object sweep.
    a_slot_wr_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_wr_en |-> (state_reg == crmfm_pkg::ST_SCAN))
        else $error("slot write outside the receive sweep");

    // A slot read is always followed by the slot capture state.
    a_slot_rd_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_rd_en |=> (state_reg == crmfm_pkg::ST_SLOT))
        else $error("slot read without capture");

    // A new result is loaded only when the output register is free.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("pending result overwritten");
`endif

endmodule

/* verif/tb_top.sv */
// Testbench for the CAN receive filter with message objects: directed and random items.
//
// What is tested and how: the testbench drives action items into the block
// and keeps its own model of the sixteen message objects, including their
// filters, ring pointers and stored frames. Each accepted item is run through
// that model at once, and the expected result item is queued. A separate
// process takes each result item from the block and compares it field by field
// with the oldest queued expectation. Configuration registers are written only
// while the block is idle: after reset, and between phases once every queued
// result has arrived.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_OBJ  = 16;
    localparam int RING_D = 16;

    // One expected or observed result item.
    typedef struct {
        bit        valid;
        bit [28:0] id;
        bit        ext;
        bit [3:0]  dlc;
        bit [63:0] data;
        bit [31:0] stamp;
        bit [4:0]  count;
        bit [15:0] map;
    } mb_result_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [crmfm_pkg::S_TDATA_W-1:0]  s_tdata;
    logic [crmfm_pkg::ACT_W-1:0]      s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [crmfm_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                             m_tuser;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [crmfm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [crmfm_pkg::CFG_DATA_W-1:0] cfg_data;

    can_rx_mask_filter_mailboxes dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // The testbench's copy of the configuration registers.
    bit        bus_is_open;
    bit [15:0] std_id_mask;
    bit [28:0] ext_id_mask;
    bit [28:0] last_obj_mask;

    // The testbench's copy of the message objects and their rings.
    bit [28:0] obj_filter [N_OBJ];
    bit        obj_is_ext [N_OBJ];
    bit [4:0]  obj_depth_q[N_OBJ];
    bit [4:0]  obj_fill   [N_OBJ];
    bit [3:0]  obj_wr     [N_OBJ];
    bit [3:0]  obj_rd     [N_OBJ];
    bit [28:0] ring_id    [N_OBJ*RING_D];
    bit [63:0] ring_data  [N_OBJ*RING_D];
    bit [31:0] ring_stamp [N_OBJ*RING_D];
    bit [3:0]  ring_dlc   [N_OBJ*RING_D];
    bit        ring_ext   [N_OBJ*RING_D];

    mb_result_t pending_results[$];

    int mismatches;
    int n_receives, n_stored, n_pops_hit, n_reg_writes, n_items;
    bit no_idle;       // when set, neither side inserts gaps
    int hold_left;     // cycles the result side still holds off

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4ms;
        $display("FAIL can_rx_mask_filter_mailboxes");
        $finish;
    end

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    endtask

    // Does object k take this frame under the current masks?
    function automatic bit obj_takes(int k, bit [28:0] id, bit ext);
        bit [28:0] m;
        if (obj_depth_q[k] == 0 || obj_is_ext[k] != ext) return 1'b0;
        if (ext) begin
            m = ext_id_mask;
            if (k == N_OBJ - 1) m &= last_obj_mask;
            return (id & m) == (obj_filter[k] & m);
        end
        m = {13'd0, std_id_mask};
        if (k == N_OBJ - 1) m &= last_obj_mask;
        return ({13'd0, id[15:0]} & m) == (obj_filter[k] & m);
    endfunction

    // Applies one item to the object model and returns the result it causes.
    function automatic mb_result_t mailbox_step(bit [2:0] act, bit [3:0] k, bit [28:0] id,
                                                 bit ext, bit [3:0] dlc, bit [63:0] data,
                                                 bit [31:0] stamp, bit [4:0] depth);
        mb_result_t r;
        int         s;
        int         nbytes;
        bit [63:0]  keep;
        bit [4:0]   d;
        r = '{default: 0};
        case (act)
            crmfm_pkg::ACT_RX: begin
                if (bus_is_open) begin
                    for (int j = 0; j < N_OBJ; j++) begin
                        if (obj_takes(j, id, ext)) begin
                            s = j * RING_D + obj_wr[j];
                            nbytes = (dlc > 8) ? 8 : dlc;
                            keep = (nbytes == 8) ? '1 : ((64'd1 << (8 * nbytes)) - 1);
                            ring_id[s] = id;
                            ring_data[s] = data & keep;
                            ring_stamp[s] = stamp;
                            ring_dlc[s] = dlc;
                            ring_ext[s] = ext;
                            obj_wr[j] = 4'((obj_wr[j] + 1) % obj_depth_q[j]);
                            // A full ring drops its oldest frame.
                            if (obj_fill[j] >= obj_depth_q[j]) obj_rd[j] = obj_wr[j];
                            else obj_fill[j]++;
                            r.map[j] = 1'b1;
                        end
                    end
                end
            end
            crmfm_pkg::ACT_POP: begin
                if (obj_depth_q[k] > 0 && obj_fill[k] > 0) begin
                    s = k * RING_D + obj_rd[k];
                    r.valid = 1'b1;
                    r.id = ring_id[s];
                    r.ext = ring_ext[s];
                    r.dlc = ring_dlc[s];
                    r.data = ring_data[s];
                    r.stamp = ring_stamp[s];
                    obj_rd[k] = 4'((obj_rd[k] + 1) % obj_depth_q[k]);
                    obj_fill[k]--;
                end
            end
            crmfm_pkg::ACT_CONFIG: begin
                d = (depth > RING_D) ? 5'(RING_D) : depth;
                obj_depth_q[k] = d;
                if (d > 0) begin
                    obj_filter[k] = id;
                    obj_is_ext[k] = ext;
                end
                obj_fill[k] = 0;
                obj_wr[k] = 0;
                obj_rd[k] = 0;
            end
            crmfm_pkg::ACT_CLEAR: begin
                obj_fill[k] = 0;
                obj_wr[k] = 0;
                obj_rd[k] = 0;
            end
            crmfm_pkg::ACT_CHANGE: begin
                obj_filter[k] = id;
                obj_is_ext[k] = ext;
            end
            default: ;
        endcase
        r.count = obj_fill[k];
        return r;
    endfunction

    // Offers one item; on acceptance, the expected result is queued. The valid
    // line stays high after acceptance so that back-to-back items keep it high.
    task automatic send_item(bit [2:0] act, bit [3:0] k, bit [28:0] id, bit ext,
                             bit [3:0] dlc, bit [63:0] data, bit [31:0] stamp,
                             bit [4:0] depth);
        int gap;
        mb_result_t r;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {5'd0, depth, stamp, data, dlc, ext, id, k};
        s_tuser  <= act;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        r = mailbox_step(act, k, id, ext, dlc, data, stamp, depth);
        pending_results.push_back(r);
        n_items++;
        if (act == crmfm_pkg::ACT_RX) begin
            n_receives++;
            if (r.map != 0) n_stored++;
        end
        if (r.valid) n_pops_hit++;
    endtask

    task automatic send_random_fields(bit [2:0] act, bit [3:0] k, bit [4:0] depth);
        send_item(act, k, 29'($urandom), 1'($urandom), 4'($urandom_range(0, 15)),
                  {$urandom, $urandom}, $urandom, depth);
    endtask

    // Lowers valid and waits until every result has been taken, then lets the
    // block settle for longer than a full receive sweep.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_reg(crmfm_pkg::cfg_reg_t idx, bit [31:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            crmfm_pkg::REG_BUS_OPEN:  bus_is_open = value[0];
            crmfm_pkg::REG_STD_MASK:  std_id_mask = value[15:0];
            crmfm_pkg::REG_EXT_MASK:  ext_id_mask = value[28:0];
            crmfm_pkg::REG_LAST_MASK: last_obj_mask = value[28:0];
            default: ;
        endcase
        n_reg_writes++;
        @(posedge aclk);
    endtask

    task automatic set_masks(bit open, bit [15:0] sm, bit [28:0] em, bit [28:0] lm);
        drain();
        write_reg(crmfm_pkg::REG_BUS_OPEN, {31'd0, open});
        write_reg(crmfm_pkg::REG_STD_MASK, {16'd0, sm});
        write_reg(crmfm_pkg::REG_EXT_MASK, {3'd0, em});
        write_reg(crmfm_pkg::REG_LAST_MASK, {3'd0, lm});
    endtask

    // Result side: takes results and compares them. Ready is idled at random,
    // and held low for a whole stretch when a hold-off is requested.
    int ready_gap;
    always @(posedge aclk) begin
        mb_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            ready_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing expected", m_tdata[63:0], 0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser != want.valid)
                        report_mismatch("msg_valid", m_tuser, want.valid);
                    if (m_tdata[28:0] != want.id)
                        report_mismatch("msg_id", m_tdata[28:0], want.id);
                    if (m_tdata[29] != want.ext)
                        report_mismatch("msg_ext", m_tdata[29], want.ext);
                    if (m_tdata[33:30] != want.dlc)
                        report_mismatch("msg_dlc", m_tdata[33:30], want.dlc);
                    if (m_tdata[97:34] != want.data)
                        report_mismatch("msg_data", m_tdata[97:34], want.data);
                    if (m_tdata[129:98] != want.stamp)
                        report_mismatch("msg_time", m_tdata[129:98], want.stamp);
                    if (m_tdata[134:130] != want.count)
                        report_mismatch("obj_count", m_tdata[134:130], want.count);
                    if (m_tdata[150:135] != want.map)
                        report_mismatch("accept_map", m_tdata[150:135], want.map);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (ready_gap > 0) begin
                ready_gap--;
                m_tready <= 1'b0;
            end else if (no_idle || $urandom_range(0, 99) < 70) begin
                m_tready <= 1'b1;
            end else begin
                ready_gap = pick_gap();
                m_tready <= 1'b0;
            end
        end
    end

    // Extremes of every field, each action, and the special cases: short and
    // oversized dlc, depth saturation, zero-depth configure, ring overwrite,
    // pop of an empty or inactive object, change filter and unknown actions.
    task automatic test_directed();
        set_masks(1'b1, 16'hFFFF, 29'h1FFFFFFF, 29'h1FFFFFFF);
        send_item(crmfm_pkg::ACT_CONFIG, 4'd0, 29'h00123, 1'b0, 0, 0, 0, 5'd4);
        send_item(crmfm_pkg::ACT_CONFIG, 4'd1, 29'h1FFFFFFF, 1'b1, 0, 0, 0, 5'd16);
        send_item(crmfm_pkg::ACT_CONFIG, 4'd15, 29'h0FFFF, 1'b0, 0, 0, 0, 5'd31);
        send_item(crmfm_pkg::ACT_CONFIG, 4'd3, 29'h00007, 1'b0, 0, 0, 0, 5'd1);
        send_item(crmfm_pkg::ACT_CONFIG, 4'd2, 29'h00555, 1'b0, 0, 0, 0, 5'd0);
        // Short payload keeps no bytes, then three, then an oversized dlc.
        send_item(crmfm_pkg::ACT_RX, 4'd0, 29'h1FFF0123, 1'b0, 4'd0, '1, 32'hFFFFFFFF,
                  5'd31);
        send_item(crmfm_pkg::ACT_RX, 4'd0, 29'h00123, 1'b0, 4'd3, '1, 32'h0, 5'd0);
        send_item(crmfm_pkg::ACT_RX, 4'd0, 29'h00123, 1'b0, 4'd15, 64'h0123456789ABCDEF,
                  32'h1, 0);
        send_item(crmfm_pkg::ACT_RX, 4'd0, 29'h1FFFFFFF, 1'b1, 4'd8, '1, 32'hFFFFFFFF, 0);
        send_item(crmfm_pkg::ACT_RX, 4'd0, 29'h0FFFF, 1'b0, 4'd8, 64'hA5A5A5A5A5A5A5A5,
                  32'h5, 0);
        // A one-deep ring: the second frame overwrites the first.
        send_item(crmfm_pkg::ACT_RX, 4'd0, 29'h00007, 1'b0, 4'd2, 64'h1111, 32'h10, 0);
        send_item(crmfm_pkg::ACT_RX, 4'd0, 29'h00007, 1'b0, 4'd2, 64'h2222, 32'h11, 0);
        send_item(crmfm_pkg::ACT_POP, 4'd3, 0, 0, 0, 0, 0, 0);
        send_item(crmfm_pkg::ACT_POP, 4'd3, 0, 0, 0, 0, 0, 0);
        send_item(crmfm_pkg::ACT_POP, 4'd0, 0, 0, 0, 0, 0, 0);
        send_item(crmfm_pkg::ACT_POP, 4'd1, 0, 0, 0, 0, 0, 0);
        send_item(crmfm_pkg::ACT_POP, 4'd15, 0, 0, 0, 0, 0, 0);
        send_item(crmfm_pkg::ACT_POP, 4'd2, 0, 0, 0, 0, 0, 0);
        send_item(crmfm_pkg::ACT_CLEAR, 4'd0, 0, 0, 0, 0, 0, 0);
        send_item(crmfm_pkg::ACT_POP, 4'd0, 0, 0, 0, 0, 0, 0);
        send_item(crmfm_pkg::ACT_CHANGE, 4'd1, 29'h00321, 1'b0, 0, 0, 0, 0);
        send_item(crmfm_pkg::ACT_RX, 4'd0, 29'h1FFF0321, 1'b0, 4'd1, '1, 32'h7, 0);
        send_item(crmfm_pkg::ACT_POP, 4'd1, 0, 0, 0, 0, 0, 0);
        send_item(3'd7, 4'd1, 0, 0, 0, 0, 0, 0);
        send_item(3'd5, 4'd0, 0, 0, 0, 0, 0, 0);
    endtask

    // One random item, mostly receives aimed at configured filters and pops.
    task automatic random_item();
        int        r;
        bit [3:0]  k;
        bit [28:0] id;
        bit        ext;
        r  = $urandom_range(0, 99);
        k  = 4'($urandom_range(0, N_OBJ - 1));
        id = obj_filter[k];
        ext = obj_is_ext[k];
        if (r < 50) begin
            if ($urandom_range(0, 9) < 2) begin
                id = 29'($urandom);
                ext = 1'($urandom);
            end else if ($urandom_range(0, 9) < 3) begin
                id[$urandom_range(0, 28)] ^= 1'b1;
            end else if (!ext) begin
                id[28:16] = 13'($urandom);
            end
            send_item(crmfm_pkg::ACT_RX, 4'($urandom), id, ext, 4'($urandom_range(0, 15)),
                      {$urandom, $urandom}, $urandom, 5'($urandom));
        end else if (r < 78) begin
            send_random_fields(crmfm_pkg::ACT_POP, k, 5'($urandom));
        end else if (r < 87) begin
            r = $urandom_range(0, 9);
            send_random_fields(crmfm_pkg::ACT_CONFIG, k,
                               (r < 7) ? 5'($urandom_range(1, 6)) :
                               (r < 9) ? 5'($urandom_range(7, 16)) :
                               5'($urandom_range(0, 1) ? 0 : $urandom_range(17, 31)));
        end else if (r < 92) begin
            send_random_fields(crmfm_pkg::ACT_CLEAR, k, 5'($urandom));
        end else if (r < 97) begin
            send_random_fields(crmfm_pkg::ACT_CHANGE, k, 5'($urandom));
        end else begin
            send_random_fields(3'($urandom_range(5, 7)), k, 5'($urandom));
        end
    endtask

    task automatic test_random_phase(int count);
        for (int i = 0; i < count; i++) random_item();
    endtask

    // Holds the result side off so that the block fills up and stalls input.
    task automatic test_backpressure();
        drain();
        hold_left = 300;
        no_idle = 1'b1;
        for (int i = 0; i < 40; i++) random_item();
        no_idle = 1'b0;
    endtask

    initial begin
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        bus_is_open = 1'b0;
        std_id_mask = 16'hFFFF;
        ext_id_mask = 29'h1FFFFFFF;
        last_obj_mask = 29'h1FFFFFFF;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_phase(250);
        // Masks at zero: every active object of the right type matches.
        set_masks(1'b1, 16'h0000, 29'h0, 29'h0);
        test_random_phase(200);
        set_masks(1'b1, 16'($urandom), 29'($urandom) | 29'h1FFF0000,
                  29'($urandom) | 29'h1FFFF000);
        test_random_phase(250);
        // Bus closed: receives store nothing.
        set_masks(1'b0, 16'hFFFF, 29'h1FFFFFFF, 29'h1FFFFFFF);
        test_random_phase(60);
        set_masks(1'b1, 16'hFF0F, 29'h1FFFFFF0, 29'h1FFFFFFF);
        test_backpressure();
        test_random_phase(250);
        drain();

        $display("Items: %0d (receives %0d, stored %0d, pops with data %0d), reg writes %0d.",
                 n_items, n_receives, n_stored, n_pops_hit, n_reg_writes);
        $display("Covered full/zero/random masks, bus closed, ring overwrite and a long stall.");
        if (mismatches == 0) begin
            $display("PASS can_rx_mask_filter_mailboxes");
        end else begin
            $display("FAIL can_rx_mask_filter_mailboxes");
        end
        $finish;
    end

endmodule

`default_nettype wire
